// File: sv/exlex_pkg.sv
// Shared types, constants and keyword tables of the expression language lexer.
`default_nettype none

package exlex_pkg;

	localparam int KEYWORD_MAX_LEN = 6;
	localparam int VALUE_BITS      = 32;
	localparam int POSITION_BITS   = 16;
	localparam int LEN_W           = 16;
	localparam int PFX_IDX_W       = $clog2(KEYWORD_MAX_LEN);

	localparam int FIFO_IDX_W = 3;
	localparam int FIFO_DEPTH = 1 << FIFO_IDX_W;
	localparam int FIFO_CNT_W = FIFO_IDX_W + 1;

	localparam logic [7:0] CH_NEWLINE    = 8'h0A;
	localparam logic [7:0] CH_EQUAL      = "=";
	localparam logic [7:0] CH_UNDERSCORE = "_";
	localparam logic [7:0] CH_ZERO       = "0";
	localparam logic [7:0] CH_NINE       = "9";

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NUMBER = 2'd1,
		MODE_WORD   = 2'd2,
		MODE_EQUAL  = 2'd3
	} scan_mode_t;

	typedef enum logic [4:0] {
		KIND_NUMBER = 5'd0,
		KIND_IDENT  = 5'd1,
		KIND_IF     = 5'd2,
		KIND_ELSE   = 5'd3,
		KIND_WHILE  = 5'd4,
		KIND_DEF    = 5'd5,
		KIND_RETURN = 5'd6,
		KIND_PLUS   = 5'd7,
		KIND_MINUS  = 5'd8,
		KIND_STAR   = 5'd9,
		KIND_SLASH  = 5'd10,
		KIND_ASSIGN = 5'd11,
		KIND_EQEQ   = 5'd12,
		KIND_LESS   = 5'd13,
		KIND_GREATER = 5'd14,
		KIND_LPAREN = 5'd15,
		KIND_RPAREN = 5'd16,
		KIND_LBRACE = 5'd17,
		KIND_RBRACE = 5'd18,
		KIND_COMMA  = 5'd19,
		KIND_SEMI   = 5'd20,
		KIND_EOF    = 5'd21
	} kind_t;

	typedef struct packed {
		kind_t                    kind;
		logic [POSITION_BITS-1:0] line;
		logic [POSITION_BITS-1:0] column;
		logic [LEN_W-1:0]         length;
		logic [VALUE_BITS-1:0]    value;
		logic                     overflow;
		logic                     last;
	} token_t;

	// Up to two tokens produced by one character, always packed from t0.
	typedef struct packed {
		logic   v0;
		logic   v1;
		token_t t0;
		token_t t1;
	} push_t;

	typedef logic [7:0] prefix_t [KEYWORD_MAX_LEN];

	localparam int KW_COUNT    = 5;
	localparam int KW_TEXT_LEN = 6;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_TEXT_LEN] = '{
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00},
		'{"w", "h", "i", "l", "e", 8'h00},
		'{"d", "e", "f", 8'h00, 8'h00, 8'h00},
		'{"r", "e", "t", "u", "r", "n"}
	};

	localparam logic [LEN_W-1:0] KW_LEN [KW_COUNT] = '{
		16'd2, 16'd4, 16'd5, 16'd3, 16'd6
	};

	localparam kind_t KW_KIND [KW_COUNT] = '{
		KIND_IF, KIND_ELSE, KIND_WHILE, KIND_DEF, KIND_RETURN
	};

	// A word is a keyword only if its full length and every kept byte match.
	function automatic kind_t word_kind(prefix_t p, logic [LEN_W-1:0] len);
		kind_t kind;
		logic  hit;
		kind = KIND_IDENT;
		for (int k = 0; k < KW_COUNT; k++) begin
			hit = (len == KW_LEN[k]);
			for (int i = 0; i < KW_TEXT_LEN; i++) begin
				if ((LEN_W'(i) < KW_LEN[k]) && (p[i] != KW_TEXT[k][i])) begin
					hit = 1'b0;
				end
			end
			if (hit) begin
				kind = KW_KIND[k];
			end
		end
		return kind;
	endfunction

endpackage

`default_nettype wire

// File: sv/exlex_core.sv
// Scanner state and per-character token decision of the lexer.
`default_nettype none

module exlex_core (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                item_valid,
	input  wire  [7:0]         char_code,
	input  wire                end_of_input,
	output exlex_pkg::push_t   push
);

	exlex_pkg::scan_mode_t mode_q, mode_d;
	logic [exlex_pkg::LEN_W-1:0]         run_len_q, run_len_d;
	logic [exlex_pkg::VALUE_BITS-1:0]    acc_q, acc_d;
	logic                                sat_q, sat_d;
	logic [exlex_pkg::POSITION_BITS-1:0] line_q, line_d;
	logic [exlex_pkg::POSITION_BITS-1:0] col_q, col_d;
	logic [exlex_pkg::POSITION_BITS-1:0] start_col_q, start_col_d;
	exlex_pkg::prefix_t                  prefix_q;

	logic                             pfx_we;
	logic [exlex_pkg::PFX_IDX_W-1:0]  pfx_idx;

	logic is_digit, is_alpha, is_word;
	logic sym_v;
	exlex_pkg::kind_t sym_kind;

	logic [exlex_pkg::VALUE_BITS-1:0] base_acc;
	logic                             base_sat;
	logic [exlex_pkg::VALUE_BITS+3:0] prod;
	logic [exlex_pkg::VALUE_BITS-1:0] acc_new;
	logic                             sat_new;
	logic [exlex_pkg::LEN_W-1:0]      run_len_inc;

	exlex_pkg::token_t fl_tok, a_tok, b_tok;
	logic              fl_v, a_v, b_v;

	always_comb begin
		is_digit = (char_code >= exlex_pkg::CH_ZERO) && (char_code <= exlex_pkg::CH_NINE);
		is_alpha = ((char_code >= "a") && (char_code <= "z")) ||
		           ((char_code >= "A") && (char_code <= "Z"));
		is_word  = is_alpha || is_digit || (char_code == exlex_pkg::CH_UNDERSCORE);
	end

	always_comb begin
		sym_v    = 1'b1;
		sym_kind = exlex_pkg::KIND_PLUS;
		unique case (char_code)
			"+": sym_kind = exlex_pkg::KIND_PLUS;
			"-": sym_kind = exlex_pkg::KIND_MINUS;
			"*": sym_kind = exlex_pkg::KIND_STAR;
			"/": sym_kind = exlex_pkg::KIND_SLASH;
			"<": sym_kind = exlex_pkg::KIND_LESS;
			">": sym_kind = exlex_pkg::KIND_GREATER;
			"(": sym_kind = exlex_pkg::KIND_LPAREN;
			")": sym_kind = exlex_pkg::KIND_RPAREN;
			"{": sym_kind = exlex_pkg::KIND_LBRACE;
			"}": sym_kind = exlex_pkg::KIND_RBRACE;
			",": sym_kind = exlex_pkg::KIND_COMMA;
			";": sym_kind = exlex_pkg::KIND_SEMI;
			default: sym_v = 1'b0;
		endcase
	end

	// Saturating value * 10 + digit; a fresh number starts from zero.
	always_comb begin
		base_acc = (mode_q == exlex_pkg::MODE_NUMBER) ? acc_q : '0;
		base_sat = (mode_q == exlex_pkg::MODE_NUMBER) ? sat_q : 1'b0;
		prod = {base_acc, 3'b000} + {2'b00, base_acc, 1'b0} +
		       (exlex_pkg::VALUE_BITS + 4)'(char_code[3:0]);
		sat_new = base_sat || (prod[exlex_pkg::VALUE_BITS+3:exlex_pkg::VALUE_BITS] != 4'd0);
		acc_new = sat_new ? '1 : prod[exlex_pkg::VALUE_BITS-1:0];
		run_len_inc = (run_len_q != '1) ? run_len_q + 1'b1 : run_len_q;
	end

	// The token a pending run gives when it ends.
	always_comb begin
		fl_v            = (mode_q != exlex_pkg::MODE_IDLE);
		fl_tok          = '0;
		fl_tok.line     = line_q;
		fl_tok.column   = start_col_q;
		fl_tok.length   = run_len_q;
		unique case (mode_q)
			exlex_pkg::MODE_NUMBER: begin
				fl_tok.kind     = exlex_pkg::KIND_NUMBER;
				fl_tok.value    = acc_q;
				fl_tok.overflow = sat_q;
			end
			exlex_pkg::MODE_WORD: begin
				fl_tok.kind = exlex_pkg::word_kind(prefix_q, run_len_q);
			end
			exlex_pkg::MODE_EQUAL: begin
				fl_tok.kind   = exlex_pkg::KIND_ASSIGN;
				fl_tok.length = exlex_pkg::LEN_W'(1);
			end
			default: begin
				fl_tok.kind = exlex_pkg::KIND_NUMBER;
			end
		endcase
	end

	always_comb begin
		mode_d      = mode_q;
		run_len_d   = run_len_q;
		acc_d       = acc_q;
		sat_d       = sat_q;
		line_d      = line_q;
		col_d       = col_q;
		start_col_d = start_col_q;
		pfx_we      = 1'b0;
		pfx_idx     = run_len_q[exlex_pkg::PFX_IDX_W-1:0];
		a_v         = 1'b0;
		a_tok       = fl_tok;
		b_v         = 1'b0;
		b_tok        = '0;
		b_tok.line   = line_q;
		b_tok.column = col_q;
		b_tok.length = exlex_pkg::LEN_W'(1);
		b_tok.kind   = sym_kind;

		if (end_of_input) begin
			a_v          = fl_v;
			b_v          = 1'b1;
			b_tok.kind   = exlex_pkg::KIND_EOF;
			b_tok.length = '0;
			mode_d       = exlex_pkg::MODE_IDLE;
			run_len_d    = '0;
			acc_d        = '0;
			sat_d        = 1'b0;
			line_d       = exlex_pkg::POSITION_BITS'(1);
			col_d        = exlex_pkg::POSITION_BITS'(1);
			start_col_d  = exlex_pkg::POSITION_BITS'(1);
		end else begin
			if (mode_q == exlex_pkg::MODE_NUMBER && is_digit) begin
				acc_d     = acc_new;
				sat_d     = sat_new;
				run_len_d = run_len_inc;
			end else if (mode_q == exlex_pkg::MODE_WORD && is_word) begin
				pfx_we    = (run_len_q < exlex_pkg::LEN_W'(exlex_pkg::KEYWORD_MAX_LEN));
				run_len_d = run_len_inc;
			end else if (mode_q == exlex_pkg::MODE_EQUAL &&
			             char_code == exlex_pkg::CH_EQUAL) begin
				a_v          = 1'b1;
				a_tok.kind   = exlex_pkg::KIND_EQEQ;
				a_tok.length = exlex_pkg::LEN_W'(2);
				mode_d       = exlex_pkg::MODE_IDLE;
			end else begin
				a_v    = fl_v;
				mode_d = exlex_pkg::MODE_IDLE;
				if (is_digit) begin
					mode_d      = exlex_pkg::MODE_NUMBER;
					start_col_d = col_q;
					run_len_d   = exlex_pkg::LEN_W'(1);
					acc_d       = acc_new;
					sat_d       = sat_new;
				end else if (is_alpha || char_code == exlex_pkg::CH_UNDERSCORE) begin
					mode_d      = exlex_pkg::MODE_WORD;
					start_col_d = col_q;
					pfx_we      = 1'b1;
					pfx_idx     = '0;
					run_len_d   = exlex_pkg::LEN_W'(1);
				end else if (char_code == exlex_pkg::CH_EQUAL) begin
					mode_d      = exlex_pkg::MODE_EQUAL;
					start_col_d = col_q;
				end else begin
					b_v = sym_v;
				end
			end

			if (char_code == exlex_pkg::CH_NEWLINE) begin
				if (line_q != '1) begin
					line_d = line_q + 1'b1;
				end
				col_d = exlex_pkg::POSITION_BITS'(1);
			end else if (col_q != '1) begin
				col_d = col_q + 1'b1;
			end
		end
	end

	// Pack the tokens from the first slot and mark the last one of the item.
	always_comb begin
		push         = '0;
		push.v0      = item_valid && (a_v || b_v);
		push.v1      = item_valid && a_v && b_v;
		push.t0      = a_v ? a_tok : b_tok;
		push.t0.last = !(a_v && b_v);
		push.t1      = b_tok;
		push.t1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= exlex_pkg::MODE_IDLE;
			run_len_q   <= '0;
			acc_q       <= '0;
			sat_q       <= 1'b0;
			line_q      <= exlex_pkg::POSITION_BITS'(1);
			col_q       <= exlex_pkg::POSITION_BITS'(1);
			start_col_q <= exlex_pkg::POSITION_BITS'(1);
		end else if (item_valid) begin
			mode_q      <= mode_d;
			run_len_q   <= run_len_d;
			acc_q       <= acc_d;
			sat_q       <= sat_d;
			line_q      <= line_d;
			col_q       <= col_d;
			start_col_q <= start_col_d;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !end_of_input && pfx_we) begin
			prefix_q[pfx_idx] <= char_code;
		end
	end

endmodule

`default_nettype wire

// File: sv/exlex_fifo.sv
// Output token queue that takes up to two tokens and gives one per cycle while popped.
`default_nettype none

module exlex_fifo (
	input  wire                                clk,
	input  wire                                arst_n,
	input  exlex_pkg::push_t                   push,
	input  wire                                pop,
	output exlex_pkg::token_t                  head_tok,
	output logic                               not_empty,
	output logic [exlex_pkg::FIFO_CNT_W-1:0]   count
);

	exlex_pkg::token_t mem_q [exlex_pkg::FIFO_DEPTH];
	logic [exlex_pkg::FIFO_IDX_W-1:0] head_q, tail_q;
	logic [exlex_pkg::FIFO_CNT_W-1:0] count_q;
	logic [exlex_pkg::FIFO_IDX_W-1:0] tail_next;
	logic do_pop;

	always_comb begin
		tail_next = tail_q + 1'b1;
		not_empty = (count_q != '0);
		do_pop    = pop && not_empty;
		head_tok  = mem_q[head_q];
		count     = count_q;
	end

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[tail_q] <= push.t0;
		end
		if (push.v1) begin
			mem_q[tail_next] <= push.t1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			tail_q  <= tail_q + exlex_pkg::FIFO_IDX_W'(push.v0) +
			           exlex_pkg::FIFO_IDX_W'(push.v1);
			head_q  <= head_q + exlex_pkg::FIFO_IDX_W'(do_pop);
			count_q <= count_q + exlex_pkg::FIFO_CNT_W'(push.v0) +
			           exlex_pkg::FIFO_CNT_W'(push.v1) - exlex_pkg::FIFO_CNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

// File: sv/expression_language_lexer_top.sv
// Top level of the expression language lexer: input stage, scanner and token queue.
// An accepted character is registered in the input stage and scanned there, and its
// tokens are written into the token queue in order. Throughput: one character per cycle
// while s_tready is high; the output port moves one token per cycle while m_tready is high,
// and the eight-entry token queue takes input only while at most four entries are in use.
// Reset (arst_n low, asynchronous): queue emptied, scanner idle at line 1, column 1.
`default_nettype none

module expression_language_lexer_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,   // [7:0] char_code
	input  wire  [0:0]  s_tuser,   // [0] end_of_input
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [87:0] m_tdata,   // [15:0] token_line, [31:16] token_column,
	                               // [47:32] token_length, [79:48] number_value,
	                               // [80] number_overflow, [87:81] zero
	output logic [4:0]  m_tuser,   // [4:0] token_kind
	output logic        m_tlast    // last_of_run
);

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       eoi_s1;

	exlex_pkg::push_t                 push;
	exlex_pkg::token_t                head_tok;
	logic                             not_empty;
	logic [exlex_pkg::FIFO_CNT_W-1:0] count;

	// Room for the staged character and a new one, two tokens each.
	assign s_tready = (count <= exlex_pkg::FIFO_CNT_W'(exlex_pkg::FIFO_DEPTH - 4));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tuser[0];
		end
	end

	exlex_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (valid_s1),
		.char_code    (char_s1),
		.end_of_input (eoi_s1),
		.push         (push)
	);

	exlex_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tready),
		.head_tok  (head_tok),
		.not_empty (not_empty),
		.count     (count)
	);

	always_comb begin
		m_tvalid = not_empty;
		m_tuser  = head_tok.kind;
		m_tlast  = head_tok.last;
		m_tdata  = {7'd0, head_tok.overflow, head_tok.value, head_tok.length,
		            head_tok.column, head_tok.line};
	end

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> ((5'(count) + 5'(push.v0) + 5'(push.v1)) <= 5'(exlex_pkg::FIFO_DEPTH)))
		else $error("token queue overflow");

	a_eof_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == exlex_pkg::KIND_EOF) |-> m_tlast)
		else $error("end-of-file token not marked last");

	a_value_only_numbers: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != exlex_pkg::KIND_NUMBER) |->
		(m_tdata[79:48] == 32'd0 && !m_tdata[80]))
		else $error("non-number token carries a value");

	a_second_needs_first: assert property (@(posedge clk) disable iff (!arst_n)
		push.v1 |-> (push.v0 && !push.t0.last && push.t1.last))
		else $error("token pair packed wrongly");

endmodule

`default_nettype wire
